@@ hdl/ptdq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdq_pkg: shared types and constants of the transfer dispatch queue
// Request and result codes, sequencer states and the descriptor layout.
// ----------------------------------------------------------------------------
package ptdq_pkg;

  localparam int DEFAULT_DEPTH = 16;

  // Hard cap on descriptors issued by one dispatch request.
  localparam logic [4:0] MAX_ISSUE = 5'd16;
  localparam logic [4:0] CFG_RESET = 5'd4;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DSP    = 2'd1,
    REQ_QRY    = 2'd2,
    REQ_CANCEL = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_ACCEPTED = 3'd0,
    STAT_REJECTED = 3'd1,
    STAT_ISSUED   = 3'd2,
    STAT_NONE     = 3'd3,
    STAT_QUERY    = 3'd4,
    STAT_CANCEL   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DSP_SCAN,
    S_DSP_EMIT,
    S_QRY_SCAN,
    S_CAN_RD,
    S_CAN_CHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [15:0] layer;
    logic [7:0]  expert;
    logic [15:0] prio;
    logic [39:0] bytes;
    logic [63:0] source;
    logic [63:0] dest;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

  // Commands to the arrival-order list.
  typedef struct packed {
    logic alloc;
    logic remove;
  } ord_cmd_t;

endpackage : ptdq_pkg
`default_nettype wire

@@ hdl/priority_transfer_dispatch_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_transfer_dispatch_queue: table of pending transfer descriptors
//
// Requests arrive as beats on in_valid/in_ready and results leave as beats on
// out_valid/out_ready, with last set on the final result of each request. An
// enqueue stores a descriptor, a dispatch issues up to max_concurrent of them
// (zero acts as one; highest priority first, oldest first on a tie), a query
// tells whether a layer/expert pair has no pending entry, and a cancel drops
// every entry of a layer. cfg_valid/cfg_ready/cfg_data set max_concurrent.
//
// One request is in work at a time; in_ready is high only while the sequencer
// is idle. An enqueue, or a dispatch on an empty table, goes straight to its
// result; a query scans every pending entry once, a cancel reads and checks
// each entry in turn, and a dispatch rescans the pending entries for every
// descriptor it issues. One comparator walks the pending entries through the
// descriptor RAM, one read per cycle.
//
// A result sits in an output register until taken; a stalled receiver holds
// the sequencer in its emit step and nothing is lost. Reset empties the table,
// clears the totals and sets max_concurrent to 4; only data read from slots
// below the fill count is ever used, so the RAM needs no clearing.
// ----------------------------------------------------------------------------
module priority_transfer_dispatch_queue #(
  parameter int QUEUE_DEPTH = ptdq_pkg::DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,
  // Request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] layer_idx,
  input  wire logic [7:0]  expert_idx,
  input  wire logic [15:0] prio_in,
  input  wire logic [39:0] byte_count,
  input  wire logic [63:0] source_addr,
  input  wire logic [63:0] dest_addr,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [15:0]      out_layer,
  output logic [7:0]       out_expert,
  output logic [15:0]      out_prio,
  output logic [39:0]      out_bytes,
  output logic [63:0]      out_source,
  output logic [63:0]      out_dest,
  output logic             done_flag,
  output logic             last,
  output logic [31:0]      completed_total,
  output logic [47:0]      bytes_total
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Sequencer and request context.
  ptdq_pkg::state_t  state;
  ptdq_pkg::state_t  state_next;
  ptdq_pkg::status_t resp_status;
  logic [4:0]        max_concurrent;
  logic [4:0]        limit;
  logic [4:0]        issue_cnt;
  logic [CNT_W-1:0]  scan_idx;
  logic              done_r;
  logic [15:0]       req_layer;
  logic [7:0]        req_expert;

  // Scan pipeline and running best candidate.
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_pos;
  logic              best_vld;
  logic [IDX_W-1:0]  best_pos;
  ptdq_pkg::desc_t   best;

  // Totals.
  logic [31:0]       issued_total;
  logic [47:0]       byte_sum;

  // Arrival-order list and descriptor store.
  ptdq_pkg::ord_cmd_t ord_cmd;
  logic [IDX_W-1:0]   ord_pos;
  logic [IDX_W-1:0]   ord_slot;
  logic [CNT_W-1:0]   fill;
  logic               ram_we;
  ptdq_pkg::desc_t    ram_wdata;
  logic [ptdq_pkg::DESC_W-1:0] ram_rdata;
  ptdq_pkg::desc_t    rd_word;

  // Decoded control.
  logic       accept;
  logic       full;
  logic       out_free;
  logic       issue_rd;
  logic       scan_done;
  logic       issue_last;
  logic       emit_issue;
  logic       emit_resp;
  logic       layer_hit;
  logic       pair_hit;
  logic [4:0] cfg_eff;

  assign rd_word   = ptdq_pkg::desc_t'(ram_rdata);
  assign full      = (fill == CNT_W'(QUEUE_DEPTH));
  assign out_free  = !out_valid || out_ready;
  assign scan_done = (scan_idx == fill) && !rd_vld;
  assign layer_hit = (rd_word.layer == req_layer);
  assign pair_hit  = layer_hit && (rd_word.expert == req_expert);
  assign cfg_ready = 1'b1;

  // A dispatch stops after limit picks or when the table runs dry.
  assign issue_last = ((issue_cnt + 5'd1) == limit) || (fill == CNT_W'(1));

  // Zero acts as one, and anything above the hard cap acts as the cap.
  always_comb begin
    if (max_concurrent == 5'd0) begin
      cfg_eff = 5'd1;
    end else if (max_concurrent > ptdq_pkg::MAX_ISSUE) begin
      cfg_eff = ptdq_pkg::MAX_ISSUE;
    end else begin
      cfg_eff = max_concurrent;
    end
  end

  ptdq_order #(
    .DEPTH (QUEUE_DEPTH)
  ) u_order (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ord_cmd),
    .pos  (ord_pos),
    .slot (ord_slot),
    .fill (fill)
  );

  ptdq_ram #(
    .WIDTH (ptdq_pkg::DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ord_slot),
    .wdata (ram_wdata),
    .raddr (ord_slot),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ptdq_pkg::S_IDLE: begin
        if (accept) begin
          case (ptdq_pkg::req_t'(req_type))
            ptdq_pkg::REQ_ENQ: state_next = ptdq_pkg::S_RESP;
            ptdq_pkg::REQ_DSP: begin
              state_next = (fill == '0) ? ptdq_pkg::S_RESP : ptdq_pkg::S_DSP_SCAN;
            end
            ptdq_pkg::REQ_QRY: state_next = ptdq_pkg::S_QRY_SCAN;
            default:           state_next = ptdq_pkg::S_CAN_RD;
          endcase
        end
      end
      ptdq_pkg::S_DSP_SCAN: begin
        if (scan_done) begin
          state_next = ptdq_pkg::S_DSP_EMIT;
        end
      end
      ptdq_pkg::S_DSP_EMIT: begin
        if (out_free) begin
          state_next = issue_last ? ptdq_pkg::S_IDLE : ptdq_pkg::S_DSP_SCAN;
        end
      end
      ptdq_pkg::S_QRY_SCAN: begin
        if (scan_done) begin
          state_next = ptdq_pkg::S_RESP;
        end
      end
      ptdq_pkg::S_CAN_RD: begin
        state_next = (scan_idx == fill) ? ptdq_pkg::S_RESP : ptdq_pkg::S_CAN_CHK;
      end
      ptdq_pkg::S_CAN_CHK: state_next = ptdq_pkg::S_CAN_RD;
      ptdq_pkg::S_RESP: begin
        if (out_free) begin
          state_next = ptdq_pkg::S_IDLE;
        end
      end
      default: state_next = ptdq_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready       = 1'b0;
    ord_pos        = scan_idx[IDX_W-1:0];
    ord_cmd.alloc  = 1'b0;
    ord_cmd.remove = 1'b0;
    issue_rd       = 1'b0;
    emit_issue     = 1'b0;
    emit_resp      = 1'b0;
    case (state)
      ptdq_pkg::S_IDLE: begin
        // The free slot at the tail of the order list takes a new entry.
        in_ready = 1'b1;
        ord_pos  = fill[IDX_W-1:0];
      end
      ptdq_pkg::S_DSP_SCAN, ptdq_pkg::S_QRY_SCAN: begin
        issue_rd = (scan_idx < fill);
      end
      ptdq_pkg::S_DSP_EMIT: begin
        ord_pos        = best_pos;
        emit_issue     = out_free;
        ord_cmd.remove = out_free;
      end
      ptdq_pkg::S_CAN_CHK: begin
        ord_cmd.remove = layer_hit;
      end
      ptdq_pkg::S_RESP: begin
        emit_resp = out_free;
      end
      default: ;
    endcase
    accept        = in_valid && in_ready;
    ram_we        = accept && (req_type == ptdq_pkg::REQ_ENQ) && !full;
    ord_cmd.alloc = ram_we;
  end

  always_comb begin
    ram_wdata.layer  = layer_idx;
    ram_wdata.expert = expert_idx;
    ram_wdata.prio   = prio_in;
    ram_wdata.bytes  = byte_count;
    ram_wdata.source = source_addr;
    ram_wdata.dest   = dest_addr;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ptdq_pkg::S_IDLE;
      max_concurrent <= ptdq_pkg::CFG_RESET;
      limit          <= ptdq_pkg::CFG_RESET;
      resp_status    <= ptdq_pkg::STAT_ACCEPTED;
      issue_cnt      <= '0;
      scan_idx       <= '0;
      done_r         <= 1'b0;
      rd_vld         <= 1'b0;
      best_vld       <= 1'b0;
      issued_total   <= '0;
      byte_sum       <= '0;
      out_valid      <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue_rd;

      if (cfg_valid && cfg_ready) begin
        max_concurrent <= cfg_data;
      end

      if (issue_rd) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end

      if (accept) begin
        limit     <= cfg_eff;
        issue_cnt <= '0;
        scan_idx  <= '0;
        best_vld  <= 1'b0;
        done_r    <= (req_type == ptdq_pkg::REQ_QRY);
        case (ptdq_pkg::req_t'(req_type))
          ptdq_pkg::REQ_ENQ: begin
            resp_status <= full ? ptdq_pkg::STAT_REJECTED : ptdq_pkg::STAT_ACCEPTED;
          end
          ptdq_pkg::REQ_DSP: resp_status <= ptdq_pkg::STAT_NONE;
          ptdq_pkg::REQ_QRY: resp_status <= ptdq_pkg::STAT_QUERY;
          default:           resp_status <= ptdq_pkg::STAT_CANCEL;
        endcase
      end

      // Strict greater-than keeps the oldest entry on a priority tie.
      if (rd_vld && (state == ptdq_pkg::S_DSP_SCAN)) begin
        if (!best_vld || (rd_word.prio > best.prio)) begin
          best_vld <= 1'b1;
        end
      end

      if (rd_vld && (state == ptdq_pkg::S_QRY_SCAN) && pair_hit) begin
        done_r <= 1'b0;
      end

      // A removed entry pulls the next one into the same position.
      if ((state == ptdq_pkg::S_CAN_CHK) && !layer_hit) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end

      if (emit_issue) begin
        issued_total <= issued_total + 32'd1;
        byte_sum     <= byte_sum + {8'd0, best.bytes};
        issue_cnt    <= issue_cnt + 5'd1;
        scan_idx     <= '0;
        best_vld     <= 1'b0;
      end

      if (emit_issue || emit_resp) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      req_layer  <= layer_idx;
      req_expert <= expert_idx;
    end
    if (issue_rd) begin
      rd_pos <= scan_idx[IDX_W-1:0];
    end
    if (rd_vld && (state == ptdq_pkg::S_DSP_SCAN)) begin
      if (!best_vld || (rd_word.prio > best.prio)) begin
        best     <= rd_word;
        best_pos <= rd_pos;
      end
    end
    if (emit_issue) begin
      status          <= ptdq_pkg::STAT_ISSUED;
      out_layer       <= best.layer;
      out_expert      <= best.expert;
      out_prio        <= best.prio;
      out_bytes       <= best.bytes;
      out_source      <= best.source;
      out_dest        <= best.dest;
      done_flag       <= 1'b0;
      last            <= issue_last;
      completed_total <= issued_total + 32'd1;
      bytes_total     <= byte_sum + {8'd0, best.bytes};
    end else if (emit_resp) begin
      status          <= resp_status;
      out_layer       <= '0;
      out_expert      <= '0;
      out_prio        <= '0;
      out_bytes       <= '0;
      out_source      <= '0;
      out_dest        <= '0;
      done_flag       <= done_r;
      last            <= 1'b1;
      completed_total <= issued_total;
      bytes_total     <= byte_sum;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count exceeds the table depth");

  a_no_alloc_remove: assert property (@(posedge clk) disable iff (rst)
    !(ord_cmd.alloc && ord_cmd.remove))
    else $error("order list allocates and removes in one cycle");

  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !rd_vld)
    else $error("read still in flight while accepting a request");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_issue && issue_last) |=> (state == ptdq_pkg::S_IDLE) && out_valid && last)
    else $error("final issued beat did not end the dispatch");

  a_total_match: assert property (@(posedge clk) disable iff (rst)
    emit_issue |=> (completed_total == issued_total) && (bytes_total == byte_sum))
    else $error("issued beat totals disagree with running totals");

endmodule : priority_transfer_dispatch_queue
`default_nettype wire

@@ hdl/ptdq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdq_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ptdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : ptdq_ram
`default_nettype wire

@@ hdl/ptdq_order.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdq_order: arrival-order list of descriptor slots
// Holds a permutation of all slot numbers. Positions below the fill count
// are pending slots, oldest first; the rest are free slots.
// ----------------------------------------------------------------------------
module ptdq_order #(
  parameter int DEPTH = ptdq_pkg::DEFAULT_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ptdq_pkg::ord_cmd_t         cmd,
  input  wire logic [$clog2(DEPTH)-1:0]   pos,
  output logic      [$clog2(DEPTH)-1:0]   slot,
  output logic      [$clog2(DEPTH+1)-1:0] fill
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0] order      [DEPTH];
  logic [IDX_W-1:0] order_next [DEPTH];

  // A removed slot leaves its position; later entries move down by one and
  // the freed slot number goes to the far end of the list.
  always_comb begin
    order_next = order;
    if (cmd.remove) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IDX_W'(i) >= pos) begin
          order_next[i] = order[i + 1];
        end
      end
      order_next[DEPTH-1] = order[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        order[i] <= IDX_W'(i);
      end
    end else begin
      order <= order_next;
      if (cmd.alloc) begin
        fill <= fill + CNT_W'(1);
      end else if (cmd.remove) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  assign slot = order[pos];

endmodule : ptdq_order
`default_nettype wire
